// ===== hdl/rwcf_pkg.sv =====
// Package for the RGB window correlation filter: sizes, register indexes and
// the control struct shared between the top level and the accumulator.
// No dependencies.
package rwcf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned AddrW     = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned SizeW     = 11;
  localparam int unsigned PixW      = 24;
  localparam int unsigned LineW     = 2 * PixW;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned KernW     = 48;
  localparam int unsigned ProdW     = 25;
  localparam int unsigned SumW      = 28;
  localparam int unsigned DivW      = 16;
  localparam int unsigned QuoW      = 35;
  localparam int unsigned ResW      = 32;
  localparam int unsigned CntW      = 6;
  localparam int unsigned OutDataW  = 120;

  typedef enum logic [2:0] {
    CfgWidth   = 3'd0,
    CfgHeight  = 3'd1,
    CfgKernTop = 3'd2,
    CfgKernMid = 3'd3,
    CfgKernBot = 3'd4,
    CfgDivisor = 3'd5,
    CfgBias    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

endpackage

// ===== hdl/rgb_window_correlation_filter_unit.sv =====
// Top level of the RGB 3x3 window correlation filter with two line stores.
// Depends on rwcf_pkg, rwcf_line_mem, rwcf_mac and rwcf_div.
//
// Channel  | Direction | Handshake                    | Payload
// pixel in | slave     | s_axis_tvalid_i/tready_o     | tdata: red, green, blue
// result   | master    | m_axis_tvalid_o/tready_i     | tdata: column, row, R, G, B
//          |           |                              | tlast: last of run
// config   | write     | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// A pixel that completes no window takes a line store read, then a write back.
// Each result it completes adds tap-serial accumulation over the nine kernel
// taps, a start of the bit-serial divider and its one-bit-per-cycle loop, a
// check that the divider has finished, and the load of the output register.
// Reset clears counters and window and restores the default configuration;
// the line stores are not cleared. A stalled output holds the next result in
// the divider.
module rgb_window_correlation_filter_unit import rwcf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [PixW-1:0]     s_axis_tdata_i,   // red[7:0], green[15:8], blue[23:16]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_column[9:0], out_row[19:10], red_out[51:20], green_out[83:52],
  // blue_out[115:84], zero padding above
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,   // last_of_run
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [KernW-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StLoad = 5'b00010,
    StMac  = 5'b00100,
    StDiv  = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [SizeW-1:0] width_q, height_q;
  logic [KernW-1:0] kern_q [3];
  logic [DivW-1:0]  divisor_q;
  logic [DivW-1:0]  bias_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= SizeW'(640);
      height_q  <= SizeW'(480);
      kern_q[0] <= '0;
      kern_q[1] <= KernW'(256);
      kern_q[2] <= '0;
      divisor_q <= DivW'(256);
      bias_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgWidth:   width_q   <= cfg_data_i[SizeW-1:0];
        CfgHeight:  height_q  <= cfg_data_i[SizeW-1:0];
        CfgKernTop: kern_q[0] <= cfg_data_i;
        CfgKernMid: kern_q[1] <= cfg_data_i;
        CfgKernBot: kern_q[2] <= cfg_data_i;
        CfgDivisor: divisor_q <= cfg_data_i[DivW-1:0];
        CfgBias:    bias_q    <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size: zero counts as one, oversize as the maximum.
  logic [SizeW-1:0] w_eff, h_eff;
  assign w_eff = (width_q == '0) ? SizeW'(1) :
                 (width_q > SizeW'(MaxWidth)) ? SizeW'(MaxWidth) : width_q;
  assign h_eff = (height_q == '0) ? SizeW'(1) :
                 (height_q > SizeW'(MaxHeight)) ? SizeW'(MaxHeight) : height_q;

  // Position of the next pixel and the pixel under work.
  logic [AddrW-1:0] col_q, cur_c_q;
  logic [RowW-1:0]  row_q, cur_r_q;
  logic [PixW-1:0]  pix_q;
  logic             row_end, last_row;

  assign row_end  = ({1'b0, col_q} + SizeW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + SizeW'(1)) >= h_eff;

  logic in_acc;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;

  // Line stores: upper half is the row before last, lower half the last row.
  logic [LineW-1:0] line_rd;
  logic             line_wr;

  assign line_wr = (state_q == StLoad);

  rwcf_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_q),
    .rd_data_o (line_rd),
    .wr_en_i   (line_wr),
    .wr_addr_i (col_q),
    .wr_data_i ({line_rd[PixW-1:0], pix_q})
  );

  // The 3x3 window: rows r-2..r, columns c-2..c, with outside neighbors zero.
  logic [PixW-1:0] win_q [3][3];
  logic [PixW-1:0] win_d [3][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (j < 2) begin
          win_d[i][j] = win_q[i][j+1];
        end else if (i == 0) begin
          win_d[i][j] = line_rd[LineW-1:PixW];
        end else if (i == 1) begin
          win_d[i][j] = line_rd[PixW-1:0];
        end else begin
          win_d[i][j] = pix_q;
        end
        if ((i == 0 && row_q < RowW'(2)) || (i == 1 && row_q == '0) ||
            (j == 0 && col_q < AddrW'(2)) || (j == 1 && col_q == '0)) begin
          win_d[i][j] = '0;
        end
      end
    end
  end

  // Pending results: bit 0 is (c-1,r-1), bit 1 (c,r-1), bit 2 (c-1,r),
  // bit 3 (c,r), emitted in that order.
  logic [3:0] pend_q, pend_new, pend_rest;
  logic [1:0] sel;

  assign pend_new[0] = (row_q != '0) && (col_q != '0);
  assign pend_new[1] = (row_q != '0) && row_end;
  assign pend_new[2] = last_row && (col_q != '0);
  assign pend_new[3] = last_row && row_end;

  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    pend_rest      = pend_q;
    pend_rest[sel] = 1'b0;
  end

  // Tap walk over the kernel, shifted by the result's offset in the window.
  logic [1:0]             ky_q, kx_q;
  logic [2:0]             wy, wx;
  logic [PixW-1:0]        tap_pix;
  logic [KernW-1:0]       kern_row;
  logic signed [CoefW-1:0] tap_coef;
  logic                   last_tap;

  assign wy       = {1'b0, ky_q} + {2'b00, sel[1]};
  assign wx       = {1'b0, kx_q} + {2'b00, sel[0]};
  assign tap_pix  = (wy > 3'd2 || wx > 3'd2) ? '0 : win_q[wy[1:0]][wx[1:0]];
  assign kern_row = kern_q[ky_q];
  assign last_tap = (ky_q == 2'd2) && (kx_q == 2'd2);

  always_comb begin
    case (kx_q)
      2'd0:    tap_coef = $signed(kern_row[CoefW-1:0]);
      2'd1:    tap_coef = $signed(kern_row[2*CoefW-1:CoefW]);
      default: tap_coef = $signed(kern_row[3*CoefW-1:2*CoefW]);
    endcase
  end

  mac_ctrl_t        mac_ctrl;
  logic [3*SumW-1:0] sums;
  logic             div_start_q, div_done;
  logic [3*ResW-1:0] div_res;

  rwcf_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .pix_i  (tap_pix),
    .coef_i (tap_coef),
    .sums_o (sums)
  );

  rwcf_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start_q),
    .sums_i    (sums),
    .divisor_i (divisor_q),
    .bias_i    ($signed(bias_q)),
    .done_o    (div_done),
    .res_o     (div_res)
  );

  // Output register parts the result channel from the datapath.
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_last_q;
  logic                out_load;
  logic [AddrW-1:0]    res_col;
  logic [RowW-1:0]     res_row;

  assign out_load = (state_q == StOut) && (!m_valid_q || m_axis_tready_i);
  assign res_col  = cur_c_q - AddrW'(1) + AddrW'(sel[0]);
  assign res_row  = cur_r_q - RowW'(1) + RowW'(sel[1]);

  always_comb begin
    state_d      = state_q;
    mac_ctrl.clr = 1'b0;
    mac_ctrl.en  = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        mac_ctrl.clr = 1'b1;
        state_d      = (pend_new != '0) ? StMac : StIdle;
      end
      StMac: begin
        mac_ctrl.en = 1'b1;
        if (last_tap) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (!div_start_q && div_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (out_load) begin
          mac_ctrl.clr = 1'b1;
          state_d      = (pend_rest != '0) ? StMac : StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      col_q       <= '0;
      row_q       <= '0;
      pend_q      <= '0;
      ky_q        <= '0;
      kx_q        <= '0;
      div_start_q <= 1'b0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else begin
      state_q     <= state_d;
      div_start_q <= (state_q == StMac) && last_tap;
      if (state_q == StLoad) begin
        win_q  <= win_d;
        pend_q <= pend_new;
        if (row_end) begin
          col_q <= '0;
          row_q <= last_row ? '0 : row_q + RowW'(1);
        end else begin
          col_q <= col_q + AddrW'(1);
        end
      end
      if (state_q == StLoad || out_load) begin
        ky_q <= '0;
        kx_q <= '0;
      end else if (state_q == StMac) begin
        if (kx_q == 2'd2) begin
          kx_q <= '0;
          ky_q <= ky_q + 2'd1;
        end else begin
          kx_q <= kx_q + 2'd1;
        end
      end
      if (out_load) begin
        pend_q    <= pend_rest;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q <= s_axis_tdata_i;
    end
    if (state_q == StLoad) begin
      cur_c_q <= col_q;
      cur_r_q <= row_q;
    end
    if (out_load) begin
      m_data_q <= OutDataW'({div_res, res_row, res_col});
      m_last_q <= (pend_rest == '0);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

// ===== hdl/rwcf_line_mem.sv =====
// Line store memory: previous row and the row before it, one word per column.
// Depends on rwcf_pkg.
module rwcf_line_mem import rwcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [LineW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [LineW-1:0] wr_data_i
);

  logic [LineW-1:0] mem [MaxWidth];
  logic [LineW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/rwcf_mac.sv =====
// Tap-serial multiply-accumulate, one kernel tap per cycle for all three
// channels. Depends on rwcf_pkg.
module rwcf_mac import rwcf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [PixW-1:0]         pix_i,
  input  logic signed [CoefW-1:0] coef_i,
  output logic [3*SumW-1:0]       sums_o
);

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [ProdW-1:0] prod;
    logic signed [SumW-1:0]  acc_q, acc_d;

    assign prod  = coef_i * $signed({1'b0, pix_i[8*ch +: 8]});
    assign acc_d = acc_q + SumW'(prod);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q <= '0;
      end else if (ctrl_i.clr) begin
        acc_q <= '0;
      end else if (ctrl_i.en) begin
        acc_q <= acc_d;
      end
    end

    assign sums_o[SumW*ch +: SumW] = acc_q;
  end

endmodule

// ===== hdl/rwcf_div.sv =====
// Bit-serial divider for three channels: (sum * 256) / divisor truncated
// toward zero, plus bias, saturated to 32 bits. Depends on rwcf_pkg.
module rwcf_div import rwcf_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [3*SumW-1:0]      sums_i,
  input  logic [DivW-1:0]        divisor_i,
  input  logic signed [DivW-1:0] bias_i,
  output logic                   done_o,
  output logic [3*ResW-1:0]      res_o
);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [DivW-1:0] dvs_q;
  logic [DivW-1:0] dvs_eff;

  // A zero divisor behaves as one.
  assign dvs_eff = (divisor_i == '0) ? DivW'(1) : divisor_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(QuoW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= dvs_eff;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [SumW-1:0] sum;
    logic [SumW-1:0]        mag;
    logic                   neg_q;
    logic [DivW-1:0]        rem_q;
    logic [QuoW-1:0]        quo_q;
    logic [DivW:0]          rem_sh;
    logic [DivW+1:0]        diff;
    logic signed [QuoW:0]   q_signed;
    logic signed [QuoW+1:0] v;

    assign sum    = $signed(sums_i[SumW*ch +: SumW]);
    assign mag    = sum[SumW-1] ? SumW'(-sum) : sum;
    assign rem_sh = {rem_q, quo_q[QuoW-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        neg_q <= sum[SumW-1];
        rem_q <= '0;
        quo_q <= {QuoW'(mag[SumW-2:0]) << 8};
      end else if (busy_q) begin
        if (!diff[DivW+1]) begin
          rem_q <= diff[DivW-1:0];
          quo_q <= {quo_q[QuoW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DivW-1:0];
          quo_q <= {quo_q[QuoW-2:0], 1'b0};
        end
      end
    end

    assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    assign v = (QuoW+2)'(q_signed) + (QuoW+2)'(bias_i);

    always_comb begin
      if (v > (QuoW+2)'(64'sd2147483647)) begin
        res_o[ResW*ch +: ResW] = 32'h7fff_ffff;
      end else if (v < -(QuoW+2)'(64'sd2147483648)) begin
        res_o[ResW*ch +: ResW] = 32'h8000_0000;
      end else begin
        res_o[ResW*ch +: ResW] = v[ResW-1:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== hdl/rwcf_checker.sv =====
// Port-level checker for the RGB window correlation filter, bound to the top.
// Depends on rwcf_pkg and rgb_window_correlation_filter_unit.
module rwcf_checker import rwcf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o,
  input logic                m_axis_tlast_o
);

  // A result item waits until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result item dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result item changed");

  // Pixels are taken one at a time.
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("pixel taken while previous one is at work");

  // No new pixel until the run of results closes with tlast.
  a_run_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("pixel accepted inside an open run of results");

endmodule

bind rgb_window_correlation_filter_unit rwcf_checker u_rwcf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== verif/tb_top.sv =====
// Self-checking testbench for rgb_window_correlation_filter_unit: full frames of
// random and corner-case RGB pixels under several register settings.
// Depends on rwcf_pkg and the filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rwcf_pkg::*;

  localparam logic [2:0] CfgUnused  = 3'd7;   // index past the register list
  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 120;   // idle time after the last expected result

  // One filtered pixel as it appears on the result port.
  typedef struct packed {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [31:0] red;
    logic signed [31:0] green;
    logic signed [31:0] blue;
    logic               last;
  } filt_res_t;

  // Predicts filtered pixels from the accepted pixel stream and checks the results.
  class rgb_filter_scoreboard;
    logic [10:0] width_reg, height_reg;
    logic [47:0] kern_rows[3];
    logic [15:0] div_reg, bias_reg;
    logic [23:0] line_prev[MaxWidth];
    logic [23:0] line_prev2[MaxWidth];
    logic [23:0] win_regs[6];
    int unsigned col_cnt, row_cnt;
    filt_res_t   pending[$];
    int          errors;

    function new();
      width_reg = 11'd640;
      height_reg = 11'd480;
      kern_rows[0] = '0;
      kern_rows[1] = 48'd256;
      kern_rows[2] = '0;
      div_reg = 16'd256;
      bias_reg = '0;
      foreach (win_regs[i]) win_regs[i] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
        CfgWidth:   width_reg = val[10:0];
        CfgHeight:  height_reg = val[10:0];
        CfgKernTop: kern_rows[0] = val;
        CfgKernMid: kern_rows[1] = val;
        CfgKernBot: kern_rows[2] = val;
        CfgDivisor: div_reg = val[15:0];
        CfgBias:    bias_reg = val[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_size(logic [10:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    // Scale by the divisor (Q8.8, truncating toward zero), add bias, saturate.
    function logic [31:0] finish_channel(longint sum);
      longint d, b, v;
      d = div_reg;
      if (d == 0) d = 1;
      b = longint'($signed(bias_reg));
      v = (sum * 256) / d + b;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_pixel(logic [23:0] pix);
      int unsigned w, h, c, r;
      bit row_end, last_row;
      logic [23:0] win[3][3];
      int coef[3][3];
      longint sum[3];
      filt_res_t res;
      filt_res_t batch[$];
      w = clamp_size(width_reg, MaxWidth);
      h = clamp_size(height_reg, MaxHeight);
      c = col_cnt % MaxWidth;
      r = row_cnt % MaxHeight;
      row_end = (c + 1 >= w);
      last_row = (r + 1 >= h);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          coef[i][j] = int'($signed(kern_rows[i][16*j +: 16]));
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win_regs[2*i];
        win[i][1] = win_regs[2*i+1];
      end
      win[0][2] = line_prev2[c];
      win[1][2] = line_prev[c];
      win[2][2] = pix;
      // Neighbors above the first row or left of the first column are zero.
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (r + i < 2 || c + j < 2) win[i][j] = '0;
      line_prev2[c] = line_prev[c];
      line_prev[c] = pix;
      for (int i = 0; i < 3; i++) begin
        win_regs[2*i] = win[i][1];
        win_regs[2*i+1] = win[i][2];
      end
      // dy/dx pick the up-left window, the one to its right at a row end, and
      // those below them in the last row.
      for (int dy = 0; dy < 2; dy++) begin
        if (dy == 0 ? r < 1 : !last_row) continue;
        for (int dx = 0; dx < 2; dx++) begin
          if (dx == 0 ? c < 1 : !row_end) continue;
          sum = '{0, 0, 0};
          for (int ky = 0; ky < 3; ky++)
            for (int kx = 0; kx < 3; kx++) begin
              if (ky + dy > 2 || kx + dx > 2) continue;
              for (int ch = 0; ch < 3; ch++)
                sum[ch] += longint'(coef[ky][kx]) * longint'(win[ky+dy][kx+dx][8*ch +: 8]);
            end
          res.col = 10'(c - 1 + dx);
          res.row = 10'(r - 1 + dy);
          res.red = finish_channel(sum[0]);
          res.green = finish_channel(sum[1]);
          res.blue = finish_channel(sum[2]);
          res.last = 1'b0;
          batch.push_back(res);
        end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
      if (row_end) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_result(filt_res_t got);
      filt_res_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", got);
        return;
      end
      exp = pending.pop_front();
      if (exp !== got) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected col %0d row %0d R %0d G %0d B %0d last %0b",
                   exp.col, exp.row, exp.red, exp.green, exp.blue, exp.last);
          $display("          actual   col %0d row %0d R %0d G %0d B %0d last %0b",
                   got.col, got.row, got.red, got.green, got.blue, got.last);
        end
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid_i = 1'b0;
  logic              s_axis_tready_o;
  logic [PixW-1:0]   s_axis_tdata_i = '0;
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic              m_axis_tlast_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [KernW-1:0]  cfg_data_i = '0;

  rgb_window_correlation_filter_unit i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  rgb_filter_scoreboard sb = new();
  bit          no_idle = 1'b0;   // set for stretches with both sides at full rate
  int unsigned cycles = 0;
  int          sink_stall = 0;
  int          rand_items = 0;

  // Idle lengths: mostly short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result sink: random backpressure, and every accepted item is checked.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result('{col: m_axis_tdata_o[9:0], row: m_axis_tdata_o[19:10],
                        red: m_axis_tdata_o[51:20], green: m_axis_tdata_o[83:52],
                        blue: m_axis_tdata_o[115:84], last: m_axis_tlast_o});
    if (sink_stall > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_stall--;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!no_idle && $urandom_range(0, 7) == 0) sink_stall = pick_gap();
    end
  end

  // One register write; cfg_valid_i then goes low before the task returns.
  task automatic write_cfg(logic [2:0] idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_all(logic [10:0] w, logic [10:0] h, logic [47:0] kt, logic [47:0] km,
                         logic [47:0] kb, logic [15:0] dv, logic [15:0] bs);
    write_cfg(CfgWidth, 48'(w));
    write_cfg(CfgHeight, 48'(h));
    write_cfg(CfgKernTop, kt);
    write_cfg(CfgKernMid, km);
    write_cfg(CfgKernBot, kb);
    write_cfg(CfgDivisor, 48'(dv));
    write_cfg(CfgBias, 48'(bs));
  endtask

  task automatic send_pixel(logic [23:0] pix);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= pix;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pixel(pix);
  endtask

  // Stop sending and let every expected result arrive, then let a pixel that
  // completes no window finish before anything else happens.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Sends a whole frame; pattern 0 is random, 1 alternates black and white,
  // 2 is all white. pause_at >= 0 holds the sender mid-frame until drained.
  task automatic send_frame(int unsigned n, int pattern, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      case (pattern)
        1:       send_pixel((i % 2) ? 24'h000000 : 24'hFFFFFF);
        2:       send_pixel(24'hFFFFFF);
        default: send_pixel(rand_pixel());
      endcase
    end
  endtask

  function automatic logic [47:0] rand_kernel_row();
    logic [47:0] v;
    if ($urandom_range(0, 1)) return {16'($urandom()), 32'($urandom())};
    for (int j = 0; j < 3; j++) v[16*j +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
    return v;
  endfunction

  initial begin
    int unsigned w, h;
    int pause_at;
    logic [15:0] dv;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Largest coefficients, smallest divisor, top bias: positive saturation.
    set_all(11'd3, 11'd3, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
            16'd1, 16'h7FFF);
    send_frame(9, 1, -1);
    drain();
    // Most negative coefficients with a zero divisor: negative saturation.
    set_all(11'd3, 11'd3, 48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
            16'd0, 16'h8000);
    send_frame(9, 2, -1);
    drain();
    // Zero width acts as one; an out-of-range index must be ignored.
    set_all(11'd0, 11'd2, 48'h0, 48'h0000_0100_0000, 48'h0, 16'hFFFF, 16'h0);
    write_cfg(CfgUnused, 48'hFFFF_FFFF_FFFF);
    send_frame(2, 0, -1);
    drain();

    // Size extremes: a single row under a zero height at full rate, then a
    // single column of several rows.
    no_idle = 1'b1;
    set_all(11'd4, 11'd0, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
            16'd256, 16'h0100);
    send_frame(4, 0, -1);
    drain();
    no_idle = 1'b0;
    set_all(11'd1, 11'd6, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
            16'd512, 16'hFF00);
    send_frame(6, 0, -1);
    drain();

    // Random small frames under random settings; the first one, if it has more
    // than five pixels, holds the sender mid-frame until every result is out.
    pause_at = 5;
    while (rand_items < 80) begin
      w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 2) : $urandom_range(2, 8);
      h = $urandom_range(1, 5);
      dv = $urandom_range(0, 2) == 0 ? 16'($urandom_range(1, 65535)) :
                                       16'($urandom_range(1, 1024));
      no_idle = ($urandom_range(0, 4) == 0);
      set_all(11'(w), 11'(h), rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
              dv, 16'($urandom()));
      send_frame(w * h, 0, (pause_at < w * h) ? pause_at : -1);
      pause_at = -1;
      rand_items += w * h;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
